// ===== rtl/tcc_pkg.sv =====
// Package for the table cell cursor with row-span reservations.
// Holds default sizes, command codes and the sequencer state type.
// No dependencies.
package tcc_pkg;

   localparam int SPAN_ROWS_DEFAULT      = 16;
   localparam int RANGES_PER_ROW_DEFAULT = 16;

   typedef enum logic [1:0] {
      CMD_ADD_COLUMNS = 2'd0,
      CMD_ADVANCE_ROWS = 2'd1,
      CMD_PLACE_CELL  = 2'd2,
      CMD_UNUSED      = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_RES_ROW,
      ST_RES_READ,
      ST_RES_SCAN,
      ST_RES_SHIFT,
      ST_SKIP_READ,
      ST_SKIP_SCAN,
      ST_SKIP_MOVE,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/tcc_if.sv =====
// Valid/ready channel interface used by the cursor block.
// Depends on nothing; the payload width is a parameter.
interface tcc_if #(parameter int WIDTH = 1) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/table_cell_cursor_rowspan.sv =====
// Channel  Dir  Payload                                        Handshake
// req      in   command, repeat_count, column_span, row_span   valid/ready
// rsp      out  cursor_column, cursor_row, overflow            valid/ready
//
// One item is processed at a time. Add columns updates the column directly.
// Advance rows adds to the row and clears the column, then skips the ranges
// reserved in the new current row and moves the remaining ranges down. Place
// cell computes its end column, reserves its range in each spanned row below,
// then runs the same skip pass. Reset is synchronous and needs no clearing pass.
// A result held on rsp does not block the next item from being taken once the
// sequencer is back in idle; that item then waits in its last state for the output.
module table_cell_cursor_rowspan #(
   parameter int SPAN_ROWS      = tcc_pkg::SPAN_ROWS_DEFAULT,
   parameter int RANGES_PER_ROW = tcc_pkg::RANGES_PER_ROW_DEFAULT
) (
   input logic clock,
   input logic reset,
   tcc_if.sink   req,
   tcc_if.source rsp
);
   localparam int RW = (SPAN_ROWS > 1) ? $clog2(SPAN_ROWS) : 1;
   localparam int KW = (RANGES_PER_ROW > 1) ? $clog2(RANGES_PER_ROW) : 1;
   localparam int CW = $clog2(RANGES_PER_ROW + 1);
   localparam int UW = $clog2(SPAN_ROWS + 1);
   localparam int AW = RW + KW;
   localparam int DEPTH = SPAN_ROWS * RANGES_PER_ROW;

   // Request payload fields.
   tcc_pkg::command_type req_command;
   logic [31:0] req_repeat_count;
   logic [15:0] req_column_span;
   logic [15:0] req_row_span;
   assign req_command      = tcc_pkg::command_type'(req.payload[65:64]);
   assign req_repeat_count = req.payload[63:32];
   assign req_column_span  = req.payload[31:16];
   assign req_row_span     = req.payload[15:0];

   tcc_pkg::state_type state_ff, state_in;
   logic [31:0] col_ff, col_in, row_ff, row_in;
   logic        ovf_ff, ovf_in;
   logic [RW-1:0] head_ff, head_in;
   logic [UW-1:0] used_ff, used_in;
   logic [CW-1:0] count_ff [SPAN_ROWS];
   logic [31:0] rep_ff, rep_in;
   logic [15:0] cspan_ff, cspan_in;
   logic [15:0] rspan_ff, rspan_in;
   logic [31:0] start_ff, start_in, next_ff, next_in;
   logic [15:0] off_ff, off_in;
   logic [RW-1:0] prow_ff, prow_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] j_ff, j_in;
   logic [47:0] prod_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [64:0] rsp_data_ff, rsp_data_in;

   // Count writes.
   logic            cnt_clear_all, cnt_we, cnt_we2;
   logic [RW-1:0]   cnt_addr, cnt_addr2;
   logic [CW-1:0]   cnt_data;

   // Memory port.
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [63:0]   mem_wdata, mem_rdata;

   tcc_range_mem #(.DEPTH(DEPTH), .AWIDTH(AW)) u_mem (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   function automatic logic [AW-1:0] addr(input logic [RW-1:0] r, input logic [CW-1:0] k);
      logic [AW-1:0] a;
      a = AW'(r) * AW'(RANGES_PER_ROW) + AW'(k);
      return a;
   endfunction

   // Offsets stay below SPAN_ROWS, so one conditional subtract wraps the ring.
   function automatic logic [RW-1:0] ring(input logic [RW-1:0] h, input logic [15:0] o);
      logic [16:0] s;
      s = 17'(h) + 17'(o);
      if (s >= 17'(SPAN_ROWS)) begin
         s = s - 17'(SPAN_ROWS);
      end
      return RW'(s);
   endfunction

   logic [32:0] sum;
   logic [48:0] psum;
   logic [CW-1:0] cur_n;
   logic [UW-1:0] off_u;

   assign req.ready     = (state_ff == tcc_pkg::ST_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.payload   = rsp_data_ff;

   // Sequencer: next state and datapath.
   always_comb begin
      state_in = state_ff;
      col_in = col_ff; row_in = row_ff; ovf_in = ovf_ff;
      head_in = head_ff; used_in = used_ff;
      rep_in = rep_ff; cspan_in = cspan_ff; rspan_in = rspan_ff;
      start_in = start_ff; next_in = next_ff; off_in = off_ff; prow_in = prow_ff;
      k_in = k_ff; pos_in = pos_ff; j_in = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in = rsp_data_ff;
      cnt_clear_all = 1'b0; cnt_we = 1'b0; cnt_we2 = 1'b0;
      cnt_addr = '0; cnt_addr2 = '0; cnt_data = '0;
      mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
      sum = '0; psum = '0;
      cur_n = count_ff[prow_ff];
      off_u = UW'(off_ff[RW:0]);
      case (state_ff)
         tcc_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               rep_in = req_repeat_count;
               cspan_in = req_column_span;
               rspan_in = req_row_span;
               case (req_command)
                  tcc_pkg::CMD_ADD_COLUMNS: begin
                     sum = {1'b0, col_ff} + {1'b0, req_repeat_count};
                     if (sum[32]) begin
                        col_in = '1; ovf_in = 1'b1;
                     end else begin
                        col_in = sum[31:0];
                     end
                     state_in = tcc_pkg::ST_DONE;
                  end
                  tcc_pkg::CMD_ADVANCE_ROWS: begin
                     sum = {1'b0, row_ff} + {1'b0, req_repeat_count};
                     if (sum[32]) begin
                        row_in = '1; ovf_in = 1'b1;
                     end else begin
                        row_in = sum[31:0];
                     end
                     col_in = '0;
                     if (req_repeat_count > 32'd1) begin
                        cnt_clear_all = 1'b1;
                        used_in = UW'(1);
                     end else if (req_repeat_count == 32'd1) begin
                        cnt_we = 1'b1; cnt_addr = head_ff;
                        head_in = ring(head_ff, 16'd1);
                        if (used_ff > UW'(1)) begin
                           used_in = used_ff - UW'(1);
                        end else begin
                           cnt_we2 = 1'b1; cnt_addr2 = ring(head_ff, 16'd1);
                        end
                     end
                     state_in = tcc_pkg::ST_SKIP_READ;
                  end
                  tcc_pkg::CMD_PLACE_CELL: begin
                     start_in = col_ff;
                     state_in = tcc_pkg::ST_MUL;
                  end
                  default: state_in = tcc_pkg::ST_DONE;
               endcase
               k_in = '0;
               prow_in = head_in;
            end
         end
         tcc_pkg::ST_MUL: begin
            // Product was registered; add it to the start column.
            psum = {17'd0, start_ff} + {1'b0, prod_ff};
            if (psum[48:32] != '0) begin
               next_in = '1; ovf_in = 1'b1;
            end else begin
               next_in = psum[31:0];
            end
            off_in = 16'd1;
            state_in = tcc_pkg::ST_RES_ROW;
         end
         tcc_pkg::ST_RES_ROW: begin
            if (off_ff >= rspan_ff) begin
               col_in = next_ff;
               prow_in = head_ff;
               k_in = '0;
               state_in = tcc_pkg::ST_SKIP_READ;
            end else if (off_ff >= 16'(SPAN_ROWS)) begin
               ovf_in = 1'b1;
               col_in = next_ff;
               prow_in = head_ff;
               k_in = '0;
               state_in = tcc_pkg::ST_SKIP_READ;
            end else begin
               prow_in = ring(head_ff, off_ff);
               // Rows beyond those in use start empty.
               if (off_u >= used_ff) begin
                  cnt_we = 1'b1; cnt_addr = ring(head_ff, off_ff);
                  used_in = off_u + UW'(1);
                  state_in = tcc_pkg::ST_RES_READ;
                  pos_in = '0;
               end else begin
                  pos_in = '0;
                  state_in = tcc_pkg::ST_RES_READ;
               end
            end
         end
         tcc_pkg::ST_RES_READ: begin
            if (cur_n >= CW'(RANGES_PER_ROW)) begin
               ovf_in = 1'b1;
               off_in = off_ff + 16'd1;
               state_in = tcc_pkg::ST_RES_ROW;
            end else if (pos_ff >= cur_n) begin
               j_in = cur_n;
               state_in = tcc_pkg::ST_RES_SHIFT;
            end else begin
               mem_raddr = addr(prow_ff, pos_ff);
               state_in = tcc_pkg::ST_RES_SCAN;
            end
         end
         tcc_pkg::ST_RES_SCAN: begin
            if (mem_rdata[63:32] <= start_ff) begin
               pos_in = pos_ff + CW'(1);
               state_in = tcc_pkg::ST_RES_READ;
            end else begin
               j_in = cur_n;
               state_in = tcc_pkg::ST_RES_SHIFT;
            end
         end
         tcc_pkg::ST_RES_SHIFT: begin
            // Two-phase: j_ff marks destination; read j-1 then write j.
            if (j_ff == pos_ff) begin
               mem_we = 1'b1;
               mem_waddr = addr(prow_ff, pos_ff);
               mem_wdata = {start_ff, next_ff};
               cnt_we = 1'b1; cnt_addr = prow_ff; cnt_data = cur_n + CW'(1);
               off_in = off_ff + 16'd1;
               state_in = tcc_pkg::ST_RES_ROW;
            end else begin
               mem_raddr = addr(prow_ff, j_ff - CW'(1));
               state_in = tcc_pkg::ST_SKIP_MOVE;
               k_in = '1;
            end
         end
         tcc_pkg::ST_SKIP_READ: begin
            if (k_ff >= cur_n) begin
               cnt_we = 1'b1; cnt_addr = prow_ff; cnt_data = '0;
               state_in = tcc_pkg::ST_DONE;
            end else begin
               mem_raddr = addr(prow_ff, k_ff);
               state_in = tcc_pkg::ST_SKIP_SCAN;
            end
         end
         tcc_pkg::ST_SKIP_SCAN: begin
            if (mem_rdata[63:32] <= col_ff) begin
               if (mem_rdata[31:0] > col_ff) begin
                  col_in = mem_rdata[31:0];
               end
               k_in = k_ff + CW'(1);
               state_in = tcc_pkg::ST_SKIP_READ;
            end else begin
               // Compact the rest down by k entries.
               j_in = k_ff;
               pos_in = '0;
               state_in = (k_ff == '0) ? tcc_pkg::ST_DONE : tcc_pkg::ST_SKIP_MOVE;
               if (k_ff != '0) begin
                  mem_raddr = addr(prow_ff, k_ff);
               end
               k_in = '0;
            end
         end
         tcc_pkg::ST_SKIP_MOVE: begin
            if (k_ff == '1) begin
               // Insert shift: data of j-1 arrived, write to j.
               mem_we = 1'b1;
               mem_waddr = addr(prow_ff, j_ff);
               mem_wdata = mem_rdata;
               j_in = j_ff - CW'(1);
               k_in = '0;
               state_in = tcc_pkg::ST_RES_SHIFT;
            end else begin
               // Skip compaction: data of j arrived, write to pos.
               mem_we = 1'b1;
               mem_waddr = addr(prow_ff, pos_ff);
               mem_wdata = mem_rdata;
               pos_in = pos_ff + CW'(1);
               j_in = j_ff + CW'(1);
               if (j_ff + CW'(1) >= cur_n) begin
                  cnt_we = 1'b1; cnt_addr = prow_ff; cnt_data = pos_ff + CW'(1);
                  state_in = tcc_pkg::ST_DONE;
               end else begin
                  mem_raddr = addr(prow_ff, j_ff + CW'(1));
               end
            end
         end
         tcc_pkg::ST_DONE: begin
            if (!(rsp_valid_ff && !rsp.ready)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {col_ff, row_ff, ovf_ff};
               state_in = tcc_pkg::ST_IDLE;
            end
         end
         default: state_in = tcc_pkg::ST_IDLE;
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcc_pkg::ST_IDLE;
         col_ff <= '0; row_ff <= '0; ovf_ff <= 1'b0;
         head_ff <= '0; used_ff <= UW'(1);
         rsp_valid_ff <= 1'b0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff <= col_in; row_ff <= row_in; ovf_ff <= ovf_in;
         head_ff <= head_in; used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff <= k_in;
      end
   end

   // Per-row range counts.
   always_ff @(posedge clock) begin
      for (int i = 0; i < SPAN_ROWS; i++) begin
         if (reset || cnt_clear_all) begin
            count_ff[i] <= '0;
         end else if ((cnt_we && cnt_addr == RW'(i)) || (cnt_we2 && cnt_addr2 == RW'(i))) begin
            count_ff[i] <= (cnt_we && cnt_addr == RW'(i)) ? cnt_data : '0;
         end
      end
   end

   // Payload registers. The product is taken from the accepted item so that
   // it is ready in the multiply state.
   always_ff @(posedge clock) begin
      rep_ff <= rep_in; cspan_ff <= cspan_in; rspan_ff <= rspan_in;
      start_ff <= start_in; next_ff <= next_in; off_ff <= off_in;
      prow_ff <= prow_in; pos_ff <= pos_in; j_ff <= j_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff <= {16'd0, rep_in} * {32'd0, cspan_in};
   end

   // A result is only loaded when the output register is free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result overwritten while stalled");
   // Overflow is sticky.
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared");
   // No item is taken while the sequencer is busy.
   assert property (@(posedge clock) disable iff (reset)
      state_ff != tcc_pkg::ST_IDLE |-> !req.ready)
      else $error("item accepted while busy");
endmodule

// ===== rtl/tcc_range_mem.sv =====
// Range store: one synchronous memory holding start and end of each range.
// Depends on nothing; one write port and one registered read port.
module tcc_range_mem #(
   parameter int DEPTH  = 256,
   parameter int AWIDTH = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AWIDTH-1:0] wr_addr,
   input  logic [63:0]       wr_data,
   input  logic [AWIDTH-1:0] rd_addr,
   output logic [63:0]       rd_data
);
   logic [63:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== tb/table_cell_cursor_rowspan_test.sv =====
// Testbench for table_cell_cursor_rowspan: random and directed commands with a
// scoreboard that predicts cursor column, cursor row and the overflow flag.
// Depends on tcc_pkg, tcc_if and the block itself.
module table_cell_cursor_rowspan_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS   = tcc_pkg::SPAN_ROWS_DEFAULT;
   localparam int RANGES = tcc_pkg::RANGES_PER_ROW_DEFAULT;
   localparam bit [31:0] ALL_ONES = 32'hFFFF_FFFF;
   localparam int IDLE_LIMIT = 8000;

   // Cursor predictor plus the queue of expected results.
   class cursor_scoreboard;
      bit [31:0] col, row;
      bit [31:0] rng_lo[ROWS*RANGES];
      bit [31:0] rng_hi[ROWS*RANGES];
      int        row_count[ROWS];
      int        head, live_rows;
      bit        sticky;
      bit [64:0] pending[$];
      int        errors;

      function new();
         col = 0; row = 0; head = 0; live_rows = 1; sticky = 0; errors = 0;
         foreach (row_count[i]) row_count[i] = 0;
      endfunction

      function bit [31:0] sat_add(bit [31:0] a, bit [63:0] b);
         bit [63:0] s;
         s = {32'd0, a} + b;
         if (s > {32'd0, ALL_ONES}) begin
            sticky = 1;
            return ALL_ONES;
         end
         return s[31:0];
      endfunction

      function int ring_row(int offset);
         return (head + offset) % ROWS;
      endfunction

      // Jump over every reserved range of the current row that starts at or
      // before the cursor, then drop those ranges.
      function void skip_reserved();
         int r, base, n, k;
         r = ring_row(0);
         base = r * RANGES;
         n = row_count[r];
         k = 0;
         while (k < n && rng_lo[base+k] <= col) begin
            if (rng_hi[base+k] > col) col = rng_hi[base+k];
            k++;
         end
         for (int j = k; j < n; j++) begin
            rng_lo[base+j-k] = rng_lo[base+j];
            rng_hi[base+j-k] = rng_hi[base+j];
         end
         row_count[r] = n - k;
      endfunction

      // Insert a range in sorted position, or drop it when the row is full.
      function void reserve(int offset, bit [31:0] lo, bit [31:0] hi);
         int r, base, n, pos;
         if (offset >= live_rows) begin
            for (int t = live_rows; t <= offset; t++) row_count[ring_row(t)] = 0;
            live_rows = offset + 1;
         end
         r = ring_row(offset);
         base = r * RANGES;
         n = row_count[r];
         if (n >= RANGES) begin
            sticky = 1;
            return;
         end
         pos = 0;
         while (pos < n && rng_lo[base+pos] <= lo) pos++;
         for (int j = n; j > pos; j--) begin
            rng_lo[base+j] = rng_lo[base+j-1];
            rng_hi[base+j] = rng_hi[base+j-1];
         end
         rng_lo[base+pos] = lo;
         rng_hi[base+pos] = hi;
         row_count[r] = n + 1;
      endfunction

      function void note_item(bit [65:0] item);
         tcc_pkg::command_type cmd;
         bit [31:0]   count, lo, hi;
         bit [15:0]   cspan, rspan;
         cmd   = tcc_pkg::command_type'(item[65:64]);
         count = item[63:32];
         cspan = item[31:16];
         rspan = item[15:0];
         case (cmd)
            tcc_pkg::CMD_ADD_COLUMNS: begin
               col = sat_add(col, {32'd0, count});
            end
            tcc_pkg::CMD_ADVANCE_ROWS: begin
               row = sat_add(row, {32'd0, count});
               col = 0;
               if (count > 1) begin
                  foreach (row_count[i]) row_count[i] = 0;
                  live_rows = 1;
               end else if (count == 1) begin
                  row_count[head] = 0;
                  head = (head + 1) % ROWS;
                  if (live_rows > 1) live_rows--;
                  else row_count[head] = 0;
               end
               skip_reserved();
            end
            tcc_pkg::CMD_PLACE_CELL: begin
               lo = col;
               hi = sat_add(lo, {48'd0, cspan} * {32'd0, count});
               for (int i = 1; i < rspan; i++) begin
                  if (i >= ROWS) begin
                     sticky = 1;
                     break;
                  end
                  reserve(i, lo, hi);
               end
               col = hi;
               skip_reserved();
            end
            default: ;
         endcase
         pending.push_back({col, row, sticky});
      endfunction

      function void check_result(bit [64:0] got);
         bit [64:0] want;
         if (pending.size() == 0) begin
            $error("result with nothing expected: column %0d row %0d overflow %0d",
                   got[64:33], got[32:1], got[0]);
            errors++;
            return;
         end
         want = pending[0];
         pending.delete(0);
         if (got[64:33] !== want[64:33]) begin
            $error("cursor_column: expected %0d, got %0d", want[64:33], got[64:33]);
            errors++;
         end
         if (got[32:1] !== want[32:1]) begin
            $error("cursor_row: expected %0d, got %0d", want[32:1], got[32:1]);
            errors++;
         end
         if (got[0] !== want[0]) begin
            $error("overflow: expected %0d, got %0d", want[0], got[0]);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   always #4 clock = ~clock;

   tcc_if #(.WIDTH(66)) req_if ();
   tcc_if #(.WIDTH(65)) rsp_if ();

   table_cell_cursor_rowspan DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_if.sink),
      .rsp  (rsp_if.source)
   );

   cursor_scoreboard board = new();
   int  send_idle_pct  = 0;
   int  recv_stall_pct = 0;
   bit  hold_wanted    = 0;
   bit  hold_done      = 0;
   int  hold_left      = 0;
   int  quiet_cycles   = 0;

   // Result side: random stalls plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 0;
         hold_left <= hold_left - 1;
      end else if (hold_wanted && !hold_done) begin
         rsp_if.ready <= 0;
         hold_left <= 400;
         hold_done <= 1;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitors feed the scoreboard; the watchdog counts cycles without progress.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) board.note_item(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) board.check_result(rsp_if.payload);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Offer one item and wait until it is taken; valid stays high afterwards.
   task automatic send_item(tcc_pkg::command_type cmd, bit [31:0] count,
                            bit [15:0] cspan, bit [15:0] rspan);
      if ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_if.valid   <= 1;
      req_if.payload <= {cmd, count, cspan, rspan};
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
   endtask

   task automatic wait_drained();
      req_if.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // Mostly small well-formed table commands.
   task automatic send_table_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 25)
         send_item(tcc_pkg::CMD_ADD_COLUMNS, $urandom_range(5), 16'($urandom),
                   16'($urandom));
      else if (pick < 48)
         send_item(tcc_pkg::CMD_ADVANCE_ROWS,
                   ($urandom_range(9) < 8) ? 1 : $urandom_range(3),
                   16'($urandom), 16'($urandom));
      else if (pick < 96)
         send_item(tcc_pkg::CMD_PLACE_CELL, $urandom_range(3), 16'($urandom_range(4)),
                   ($urandom_range(9) < 8) ? 16'($urandom_range(5))
                                           : 16'($urandom_range(20)));
      else
         send_item(tcc_pkg::CMD_UNUSED, $urandom, 16'($urandom), 16'($urandom));
   endtask

   initial begin
      req_if.valid   = 0;
      req_if.payload = '0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed part that keeps the overflow flag clear.
      send_item(tcc_pkg::CMD_UNUSED, ALL_ONES, 16'hFFFF, 16'hFFFF);
      send_item(tcc_pkg::CMD_ADD_COLUMNS, 0, 0, 0);
      send_item(tcc_pkg::CMD_ADD_COLUMNS, ALL_ONES, 16'hFFFF, 16'hFFFF);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 1, 0, 0);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 0, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 3, 0, 3);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 2, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 2, 1);
      send_item(tcc_pkg::CMD_PLACE_CELL, 2, 3, 4);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 1, 3);
      send_item(tcc_pkg::CMD_ADD_COLUMNS, 5, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 2, 2);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 1, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 0, 1, 0);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 1, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 1, 16);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 2, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 1, 0);
      wait_drained();

      // Random phases with different idle and stall mixes.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 81 : (phase == 3) ? 19 : 0;
         recv_stall_pct = (phase == 2) ? 81 : (phase == 3) ? 19 : 0;
         if (phase == 1) hold_wanted = 1;
         for (int n = 0; n < 360; n++) send_table_item();
         wait_drained();
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;

      // Overflow cases: a full row, a span past the ring, saturation.
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 2, 0, 0);
      for (int n = 0; n < 18; n++) send_item(tcc_pkg::CMD_PLACE_CELL, 1, 1, 2);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 1, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 1, 17);
      send_item(tcc_pkg::CMD_PLACE_CELL, 1, 16'hFFFF, 16'hFFFF);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, 1, 0, 0);
      send_item(tcc_pkg::CMD_PLACE_CELL, ALL_ONES, 16'hFFFF, 3);
      send_item(tcc_pkg::CMD_ADD_COLUMNS, ALL_ONES, 0, 0);

      // Full-range noise, with row advances pulling the column back.
      recv_stall_pct = 19;
      for (int n = 0; n < 90; n++) begin
         if (n % 3 == 0) send_table_item();
         else send_item(tcc_pkg::command_type'($urandom_range(3)), $urandom,
                        16'($urandom), 16'($urandom));
      end
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, ALL_ONES, 0, 0);
      send_item(tcc_pkg::CMD_ADVANCE_ROWS, ALL_ONES, 0, 0);
      wait_drained();
      repeat (700) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/tcc_pkg.sv
rtl/tcc_if.sv
rtl/tcc_range_mem.sv
rtl/table_cell_cursor_rowspan.sv
tb/table_cell_cursor_rowspan_test.sv
